FILE: hdl/sha1_hash_engine_macros.svh
// ----------------------------------------------------------------------------
// sha1 hash engine assertion macros
// concurrent check helpers used by the engine's assertions
// ----------------------------------------------------------------------------
`ifndef SHA1_HASH_ENGINE_MACROS_SVH
`define SHA1_HASH_ENGINE_MACROS_SVH

// same-cycle implication, disabled in reset
`define SHA1_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define SHA1_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/sha1_pkg.sv
// ----------------------------------------------------------------------------
// sha1 package
// shared types, constants and helpers of the sha1 hash engine
// ----------------------------------------------------------------------------
package sha1_pkg;

  typedef logic [31:0] word_t;

  // working variables a..e, index 0 is a
  typedef logic [4:0][31:0] work_t;

  localparam word_t IV0 = 32'h6745_2301;
  localparam word_t IV1 = 32'hEFCD_AB89;
  localparam word_t IV2 = 32'h98BA_DCFE;
  localparam word_t IV3 = 32'h1032_5476;
  localparam word_t IV4 = 32'hC3D2_E1F0;
  localparam work_t IV_ALL = {IV4, IV3, IV2, IV1, IV0};

  localparam word_t K0 = 32'h5A82_7999;
  localparam word_t K1 = 32'h6ED9_EBA1;
  localparam word_t K2 = 32'h8F1B_BCDC;
  localparam word_t K3 = 32'hCA62_C1D6;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam word_t PAD_WORD = {PAD_BYTE, 24'h0};

  localparam int ROUNDS = 80;
  localparam int SCHED_DEPTH = 16;

  // control from the sequencer to the schedule line
  typedef struct packed {
    logic push;    // load a message word
    logic step;    // advance one round
    logic expand;  // round 16 onwards: derive the word
  } sched_ctrl_t;

  function automatic word_t rotl(input word_t x, input int unsigned n);
    rotl = (x << n) | (x >> (32 - n));
  endfunction

endpackage

FILE: hdl/sha1_if.sv
// ----------------------------------------------------------------------------
// sha1 channel interfaces
// valid/ready channels for message words and digest words
// ----------------------------------------------------------------------------
interface sha1_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] msg_word;
  logic [2:0]  byte_count;
  logic        final_word;

  modport source (output valid, msg_word, byte_count, final_word, input ready);
  modport sink   (input valid, msg_word, byte_count, final_word, output ready);
endinterface

interface sha1_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic        digest_last;

  modport source (output valid, digest_word, digest_last, input ready);
  modport sink   (input valid, digest_word, digest_last, output ready);
endinterface

FILE: hdl/sha1_sched.sv
// ----------------------------------------------------------------------------
// sha1 message schedule
// sixteen-word shift line holding the block and its rolling expansion
// ----------------------------------------------------------------------------
module sha1_sched
  import sha1_pkg::*;
(
  input  logic        clk,
  input  sched_ctrl_t ctrl,
  input  word_t       push_word,
  output word_t       round_word
);

  // s_r[0] holds w[t-16] during expansion, w[t] in the first sixteen rounds
  word_t s_r [SCHED_DEPTH];

  assign round_word = ctrl.expand ? rotl(s_r[13] ^ s_r[8] ^ s_r[2] ^ s_r[0], 1) : s_r[0];

  always_ff @(posedge clk) begin
    if (ctrl.push || ctrl.step) begin
      for (int i = 0; i < SCHED_DEPTH - 1; i++) begin
        s_r[i] <= s_r[i+1];
      end
      s_r[SCHED_DEPTH-1] <= ctrl.push ? push_word : round_word;
    end
  end

endmodule

FILE: hdl/sha1_round.sv
// ----------------------------------------------------------------------------
// sha1 round unit
// one compression round, shared over all eighty rounds
// ----------------------------------------------------------------------------
module sha1_round
  import sha1_pkg::*;
(
  input  work_t       work_in,
  input  word_t       w,
  input  logic [6:0]  round_idx,
  output work_t       work_out
);

  word_t f;
  word_t k;
  word_t b;
  word_t c;
  word_t d;

  assign b = work_in[1];
  assign c = work_in[2];
  assign d = work_in[3];

  always_comb begin
    if (round_idx < 7'd20) begin
      f = (b & c) | (~b & d);
      k = K0;
    end else if (round_idx < 7'd40) begin
      f = b ^ c ^ d;
      k = K1;
    end else if (round_idx < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = K2;
    end else begin
      f = b ^ c ^ d;
      k = K3;
    end
  end

  assign work_out[0] = rotl(work_in[0], 5) + f + work_in[4] + k + w;
  assign work_out[1] = work_in[0];
  assign work_out[2] = rotl(b, 30);
  assign work_out[3] = c;
  assign work_out[4] = d;

endmodule

FILE: hdl/sha1_hash_engine.sv
// input: a word that does not fill a block is taken without holding the input; one that
// fills a block holds the input for the push, 80 rounds on the shared round unit and the add
// final word: one padding word a cycle while no block compresses, then 80 rounds and the
// add per block it completes (one or two), then five digest beats
// reset: synchronous active-low rst_n restores the initial chaining values and
// clears counters and length; the schedule line is not reset
// ----------------------------------------------------------------------------
// sha1 hash engine
// streaming sha-1 with in-block padding and a five-beat digest output
// ----------------------------------------------------------------------------
`include "sha1_hash_engine_macros.svh"

module sha1_hash_engine
  import sha1_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  sha1_in_if.sink           in_chan,
  sha1_out_if.source        out_chan
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ROUND = 5'b00010,
    S_ADD   = 5'b00100,
    S_PAD   = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t      state_r,  state_nxt;
  work_t       chain_r,  chain_nxt;
  work_t       work_r,   work_nxt;
  logic [3:0]  wib_r,    wib_nxt;
  logic [6:0]  round_r,  round_nxt;
  logic [63:0] len_r,    len_nxt;
  logic [2:0]  idx_r,    idx_nxt;
  logic        pad_r,    pad_nxt;
  logic        marker_r, marker_nxt;
  logic        hi_r,     hi_nxt;
  logic        lo_r,     lo_nxt;

  sched_ctrl_t sctrl;
  word_t       push_data;
  word_t       round_word;
  work_t       round_out;
  logic [5:0]  len_inc;
  logic        in_fire;
  logic        out_fire;

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;

  assign out_chan.valid       = (state_r == S_OUT);
  assign out_chan.digest_word = chain_r[idx_r];
  assign out_chan.digest_last = (idx_r == 3'd4);
  assign out_fire             = out_chan.valid && out_chan.ready;

  sha1_sched u_sched (
    .clk        (clk),
    .ctrl       (sctrl),
    .push_word  (push_data),
    .round_word (round_word)
  );

  sha1_round u_round (
    .work_in   (work_r),
    .w         (round_word),
    .round_idx (round_r),
    .work_out  (round_out)
  );

  always_comb begin
    state_nxt  = state_r;
    chain_nxt  = chain_r;
    work_nxt   = work_r;
    wib_nxt    = wib_r;
    round_nxt  = round_r;
    len_nxt    = len_r;
    idx_nxt    = idx_r;
    pad_nxt    = pad_r;
    marker_nxt = marker_r;
    hi_nxt     = hi_r;
    lo_nxt     = lo_r;
    sctrl      = '0;
    push_data  = '0;
    len_inc    = 6'd32;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          sctrl.push = 1'b1;
          if (!in_chan.final_word) begin
            push_data = in_chan.msg_word;
            len_nxt   = len_r + 64'd32;
          end else begin
            pad_nxt   = 1'b1;
            state_nxt = S_PAD;
            case (in_chan.byte_count) inside
              3'd0: begin
                len_inc   = 6'd0;
                push_data = PAD_WORD;
              end
              3'd1: begin
                len_inc   = 6'd8;
                push_data = {in_chan.msg_word[31:24], PAD_BYTE, 16'h0};
              end
              3'd2: begin
                len_inc   = 6'd16;
                push_data = {in_chan.msg_word[31:16], PAD_BYTE, 8'h0};
              end
              3'd3: begin
                len_inc   = 6'd24;
                push_data = {in_chan.msg_word[31:8], PAD_BYTE};
              end
              default: begin
                // full word: the marker byte follows in a word of its own
                len_inc    = 6'd32;
                push_data  = in_chan.msg_word;
                marker_nxt = 1'b1;
              end
            endcase
            len_nxt = len_r + {58'd0, len_inc};
          end
        end
      end
      S_PAD: begin
        sctrl.push = 1'b1;
        if (marker_r) begin
          push_data  = PAD_WORD;
          marker_nxt = 1'b0;
        end else if (wib_r == 4'd15 && hi_r) begin
          push_data = len_r[31:0];
          lo_nxt    = 1'b1;
        end else if (wib_r == 4'd14) begin
          push_data = len_r[63:32];
          hi_nxt    = 1'b1;
        end else begin
          push_data = '0;
        end
      end
      S_ROUND: begin
        sctrl.step   = 1'b1;
        sctrl.expand = (round_r >= 7'(SCHED_DEPTH));
        work_nxt     = round_out;
        if (round_r == 7'(ROUNDS - 1)) begin
          round_nxt = '0;
          state_nxt = S_ADD;
        end else begin
          round_nxt = round_r + 7'd1;
        end
      end
      S_ADD: begin
        for (int i = 0; i < 5; i++) begin
          chain_nxt[i] = chain_r[i] + work_r[i];
        end
        if (lo_r) begin
          state_nxt = S_OUT;
        end else if (pad_r) begin
          state_nxt = S_PAD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_OUT: begin
        if (out_fire) begin
          if (idx_r == 3'd4) begin
            // digest delivered: restart for the next message
            idx_nxt   = '0;
            chain_nxt = IV_ALL;
            len_nxt   = '0;
            pad_nxt   = 1'b0;
            hi_nxt    = 1'b0;
            lo_nxt    = 1'b0;
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r + 3'd1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // a push that fills the block starts the compression
    if (sctrl.push) begin
      wib_nxt = wib_r + 4'd1;
      if (wib_r == 4'd15) begin
        work_nxt  = chain_r;
        state_nxt = S_ROUND;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      chain_r  <= IV_ALL;
      work_r   <= '0;
      wib_r    <= '0;
      round_r  <= '0;
      len_r    <= '0;
      idx_r    <= '0;
      pad_r    <= 1'b0;
      marker_r <= 1'b0;
      hi_r     <= 1'b0;
      lo_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      chain_r  <= chain_nxt;
      work_r   <= work_nxt;
      wib_r    <= wib_nxt;
      round_r  <= round_nxt;
      len_r    <= len_nxt;
      idx_r    <= idx_nxt;
      pad_r    <= pad_nxt;
      marker_r <= marker_nxt;
      hi_r     <= hi_nxt;
      lo_r     <= lo_nxt;
    end
  end

  `SHA1_ASSERT_NOW(a_round_range, state_r == S_ROUND, round_r < 7'(ROUNDS), "round overrun")
  `SHA1_ASSERT_NOW(a_out_aligned, state_r == S_OUT, wib_r == 4'd0 && lo_r, "digest off block")
  `SHA1_ASSERT_NEXT(a_final_pads, in_fire && in_chan.final_word, pad_r, "final beat not padded")
  `SHA1_ASSERT_NEXT(a_restart, out_fire && out_chan.digest_last, chain_r == IV_ALL && len_r == 64'd0, "no restart")

endmodule

FILE: tb/sha1_hash_engine_tb.sv
// ----------------------------------------------------------------------------
// sha1 hash engine testbench
// streams messages word by word into the engine and checks every digest beat
// against a behavioural sha-1 model with in-block padding. both channels idle
// at random, with one full-rate stretch and one long digest hold-off
// ----------------------------------------------------------------------------
module sha1_hash_engine_tb
  import sha1_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    word_t word;
    logic  last;
  } digest_beat_t;

  logic clk;
  logic rst_n;

  sha1_in_if  in_if();
  sha1_out_if out_if();

  sha1_hash_engine i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  // model state
  word_t        chain_h [5];
  word_t        sched_w [16];
  logic [3:0]   blk_pos;
  logic [63:0]  msg_bits;
  digest_beat_t digest_q [$];

  // run control and bookkeeping
  bit           idle_en;
  int           hold_left;
  int           words_sent;
  int           msgs_sent;
  int           beats_checked;
  int           fail_count;
  digest_beat_t exp_beat;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    #10ms;
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // model
  // ---------------------------------------------------------------------------
  function automatic void restart_chain();
    chain_h[0] = IV0;
    chain_h[1] = IV1;
    chain_h[2] = IV2;
    chain_h[3] = IV3;
    chain_h[4] = IV4;
    msg_bits   = '0;
    blk_pos    = '0;
  endfunction

  function automatic void compress_block();
    word_t a, b, c, d, e, f, kc, w, sum;
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 16) begin
        w = sched_w[r];
      end else begin
        w = sched_w[(r + 13) % 16] ^ sched_w[(r + 8) % 16] ^
            sched_w[(r + 2) % 16] ^ sched_w[r % 16];
        w = {w[30:0], w[31]};
        sched_w[r % 16] = w;
      end
      if (r < 20) begin
        f  = (b & c) | (~b & d);
        kc = K0;
      end else if (r < 40) begin
        f  = b ^ c ^ d;
        kc = K1;
      end else if (r < 60) begin
        f  = (b & c) | (b & d) | (c & d);
        kc = K2;
      end else begin
        f  = b ^ c ^ d;
        kc = K3;
      end
      sum = {a[26:0], a[31:27]} + f + e + kc + w;
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = sum;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endfunction

  function automatic void load_word(word_t w);
    sched_w[blk_pos] = w;
    blk_pos++;
    if (blk_pos == 0) compress_block();
  endfunction

  function automatic void predict_digest(word_t w, logic [2:0] cnt, logic fin);
    int    n;
    word_t keep;
    if (!fin) begin
      load_word(w);
      msg_bits += 64'd32;
      return;
    end
    n = (cnt > 3'd4) ? 4 : int'(cnt);
    msg_bits += 64'(8 * n);
    if (n == 4) begin
      load_word(w);
      load_word(PAD_WORD);
    end else if (n == 0) begin
      load_word(PAD_WORD);
    end else begin
      keep = 32'hFFFF_FFFF << (32 - 8 * n);
      load_word((w & keep) | (PAD_WORD >> (8 * n)));
    end
    while (blk_pos != 4'd14) load_word('0);
    load_word(msg_bits[63:32]);
    load_word(msg_bits[31:0]);
    for (int k = 0; k < 5; k++) digest_q.push_back('{chain_h[k], k == 4});
    restart_chain();
  endfunction

  // ---------------------------------------------------------------------------
  // sender
  // ---------------------------------------------------------------------------
  task automatic send_word(input word_t w, input logic [2:0] cnt, input logic fin);
    while (idle_en && $urandom_range(99) < 33) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid      = 1'b1;
    in_if.msg_word   = w;
    in_if.byte_count = cnt;
    in_if.final_word = fin;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    predict_digest(w, cnt, fin);
    words_sent++;
    if (fin) msgs_sent++;
    @(negedge clk);
    in_if.valid = 1'b0;
  endtask

  task automatic send_message(input int n_words, input logic [2:0] last_cnt);
    for (int i = 0; i < n_words; i++) send_word($urandom, 3'($urandom_range(7)), 1'b0);
    send_word($urandom, last_cnt, 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random idling, plus a hold-off counted down here
  // ---------------------------------------------------------------------------
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_if.ready = 1'b0;
        hold_left--;
      end else begin
        out_if.ready = idle_en ? ($urandom_range(99) >= 33) : 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // digest checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (digest_q.size() == 0) begin
        $error("digest beat %h with nothing expected", out_if.digest_word);
        fail_count++;
      end else begin
        exp_beat = digest_q.pop_front();
        beats_checked++;
        if (out_if.digest_word !== exp_beat.word) begin
          $error("digest_word: expected %h, got %h", exp_beat.word, out_if.digest_word);
          fail_count++;
        end
        if (out_if.digest_last !== exp_beat.last) begin
          $error("digest_last: expected %b, got %b", exp_beat.last, out_if.digest_last);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // one-word messages over every byte count, with junk in the unused bytes
  task automatic test_final_byte_counts();
    for (int c = 0; c < 8; c++) begin
      send_word((c % 2 == 0) ? 32'hFFFF_FFFF : 32'h0000_0000, 3'(c), 1'b1);
    end
    send_word(32'h6162_63A5, 3'd3, 1'b1);
  endtask

  // byte count on non-final words is don't-care, empty final word pads in place
  task automatic test_ignored_counts();
    send_word(32'h6162_6364, 3'd0, 1'b0);
    send_word(32'hDEAD_BEEF, 3'd0, 1'b1);
    send_word(32'h0123_4567, 3'd7, 1'b0);
    send_word(32'h89AB_CDEF, 3'd5, 1'b1);
  endtask

  // digest side held off while the sender keeps pushing, so the engine backs up
  task automatic test_back_pressure();
    idle_en   = 1'b0;
    hold_left = 1500;
    for (int m = 0; m < 4; m++) send_message(m, 3'($urandom_range(7)));
    idle_en = 1'b1;
  endtask

  // long stretch with both sides at full rate
  task automatic test_full_rate();
    idle_en = 1'b0;
    for (int m = 0; m < 6; m++) send_message($urandom_range(13, 33), 3'($urandom_range(7)));
    idle_en = 1'b1;
  endtask

  // random messages, lengths weighted towards the padding boundaries
  task automatic test_random_messages(input int n_items);
    int stop_at;
    int pick;
    stop_at = words_sent + n_items;
    while (words_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 50)      send_message($urandom_range(0, 12), 3'($urandom_range(7)));
      else if (pick < 85) send_message($urandom_range(12, 18), 3'($urandom_range(7)));
      else                send_message($urandom_range(19, 47), 3'($urandom_range(7)));
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    idle_en          = 1'b1;
    hold_left        = 0;
    words_sent       = 0;
    msgs_sent        = 0;
    beats_checked    = 0;
    fail_count       = 0;
    in_if.valid      = 1'b0;
    in_if.msg_word   = '0;
    in_if.byte_count = '0;
    in_if.final_word = 1'b0;
    restart_chain();
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    test_final_byte_counts();
    test_ignored_counts();
    test_back_pressure();
    test_full_rate();
    test_random_messages(360);

    while (digest_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("sent %0d message words in %0d messages, checked %0d digest beats",
             words_sent, msgs_sent, beats_checked);
    $display("covered all final byte counts, block-boundary padding, idling and hold-off");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
